// ===== rtl/core/qsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Query slot allocator package
// Shared types, codes and sizing constants for the slot allocator blocks.
// ----------------------------------------------------------------------------
package qsa_pkg;

  // Default number of query slots, and the fixed widths of the beat fields.
  localparam int DEFAULT_SLOTS = 64;
  localparam int IDX_PORT_W    = 6;
  localparam int CNT_W         = 7;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_MARK     = 2'd1,
    REQ_ROLLBACK = 2'd2,
    REQ_LIST     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_READY_QUERY   = 2'd0,
    ST_QUERY_PENDING = 2'd1,
    ST_READY_RESET   = 2'd2,
    ST_RESET_PENDING = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_REJECTED = 2'd2,
    STAT_NO_MATCH = 2'd3
  } status_t;

  // Classified command as the back end sees it.
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REJECT = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_PORT_W-1:0]   idx;
    slot_st_t                tgt;
    logic                    in_range;
  } cmd_t;

  // Handshake bundle for a command travelling into or out of the queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_PICK = 1'b1
  } back_st_t;

endpackage

// ===== rtl/core/qsa_front.sv =====
// ----------------------------------------------------------------------------
// Query slot allocator front end
// Accepts request beats, classifies them and holds one command for the queue.
// ----------------------------------------------------------------------------
module qsa_front #(
  parameter int SLOTS = qsa_pkg::DEFAULT_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [qsa_pkg::IDX_PORT_W-1:0] slot_index,
  input  logic [1:0]                    target_state,
  output qsa_pkg::cmd_beat_t            push,
  input  logic                          push_ready
);
  import qsa_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_next;
  logic accept;

  assign in_ready = !cmd_valid || push_ready;
  assign accept   = in_valid && in_ready;

  // Rollback only takes the two ready states; anything else is rejected here.
  always_comb begin
    cmd_next.idx      = slot_index;
    cmd_next.tgt      = slot_st_t'(target_state);
    cmd_next.in_range = ({1'b0, slot_index} < CNT_W'(SLOTS));
    case (req_t'(req_type))
      REQ_ALLOC:    cmd_next.kind = CMD_ALLOC;
      REQ_MARK:     cmd_next.kind = CMD_WRITE;
      REQ_ROLLBACK: begin
        if (slot_st_t'(target_state) == ST_READY_QUERY ||
            slot_st_t'(target_state) == ST_READY_RESET) begin
          cmd_next.kind = CMD_WRITE;
        end else begin
          cmd_next.kind = CMD_REJECT;
        end
      end
      REQ_LIST:     cmd_next.kind = CMD_LIST;
      default:      cmd_next.kind = CMD_ALLOC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (push_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

  assign push.valid = cmd_valid;
  assign push.cmd   = cmd;

endmodule

// ===== rtl/core/qsa_fifo.sv =====
// ----------------------------------------------------------------------------
// Query slot allocator command queue
// Small first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module qsa_fifo #(
  parameter int DEPTH = qsa_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  qsa_pkg::cmd_beat_t push,
  output logic               push_ready,
  output qsa_pkg::cmd_beat_t head,
  input  logic               pop
);
  import qsa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cmd_t              entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_QW'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

endmodule

// ===== rtl/core/qsa_back.sv =====
// ----------------------------------------------------------------------------
// Query slot allocator back end
// Owns the slot table and counters, runs the searches and drives the results.
// ----------------------------------------------------------------------------
module qsa_back #(
  parameter int SLOTS = qsa_pkg::DEFAULT_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qsa_pkg::cmd_beat_t             head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [qsa_pkg::IDX_PORT_W-1:0] found_index,
  output logic [qsa_pkg::CNT_W-1:0]      free_count,
  output logic [qsa_pkg::CNT_W-1:0]      active_count,
  output logic                           last
);
  import qsa_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  back_st_t          state;
  back_st_t          state_next;
  slot_st_t          slots [SLOTS];
  logic [IDX_W-1:0]  ptr;
  logic [CNT_W-1:0]  free_slots;
  logic [CNT_W-1:0]  active_slots;
  cmd_kind_t         kind;
  logic [SLOTS-1:0]  vec;
  logic [SLOTS-1:0]  hi;

  logic              out_free;
  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  ge_ptr;
  slot_st_t          want;
  logic [SLOTS-1:0]  pick_src;
  logic [SLOTS-1:0]  onehot;
  logic [SLOTS-1:0]  rest;
  logic              any;
  logic [IDX_W-1:0]  pick_idx;
  logic [CNT_W-1:0]  free_inc;
  logic [CNT_W-1:0]  free_dec;
  logic [CNT_W-1:0]  active_inc;
  logic [CNT_W-1:0]  active_dec;

  logic              capture;
  logic              emit;
  status_t           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [CNT_W-1:0]  res_free;
  logic [CNT_W-1:0]  res_active;
  logic              res_last;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  slot_st_t          wr_val;
  logic              ptr_en;

  assign out_free = !out_valid || out_ready;

  // Per-slot flags against the wanted state, and the round-robin upper half.
  assign want = (head.cmd.kind == CMD_ALLOC) ? ST_READY_QUERY : head.cmd.tgt;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = (slots[i] == want);
      ge_ptr[i] = (IDX_W'(i) >= ptr);
    end
  end

  // Lowest set bit of the chosen vector, then an OR encoder.
  assign pick_src = (kind == CMD_ALLOC && hi != '0) ? hi : vec;
  assign onehot   = pick_src & (~pick_src + 1'b1);
  assign rest     = vec & ~onehot;
  assign any      = (pick_src != '0);
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (onehot[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

  assign free_inc   = (free_slots < CNT_W'(SLOTS)) ? free_slots + 1'b1 : free_slots;
  assign free_dec   = (free_slots != '0) ? free_slots - 1'b1 : free_slots;
  assign active_inc = (active_slots < CNT_W'(SLOTS)) ? active_slots + 1'b1 : active_slots;
  assign active_dec = (active_slots != '0) ? active_slots - 1'b1 : active_slots;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head.valid &&
            (head.cmd.kind == CMD_ALLOC || head.cmd.kind == CMD_LIST)) begin
          state_next = B_PICK;
        end
      end
      B_PICK: begin
        if (out_free && (kind == CMD_ALLOC || rest == '0)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control and result values.
  always_comb begin
    pop        = 1'b0;
    capture    = 1'b0;
    emit       = 1'b0;
    res_status = STAT_OK;
    res_idx    = '0;
    res_free   = free_slots;
    res_active = active_slots;
    res_last   = 1'b1;
    wr_en      = 1'b0;
    wr_idx     = head.cmd.idx[IDX_W-1:0];
    wr_val     = head.cmd.tgt;
    ptr_en     = 1'b0;
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          case (head.cmd.kind)
            CMD_ALLOC, CMD_LIST: begin
              pop     = 1'b1;
              capture = 1'b1;
            end
            CMD_WRITE: begin
              if (out_free) begin
                pop  = 1'b1;
                emit = 1'b1;
                if (head.cmd.in_range) begin
                  wr_en = 1'b1;
                  if (head.cmd.tgt == ST_READY_QUERY) begin
                    res_free   = free_inc;
                    res_active = active_dec;
                  end
                end
              end
            end
            CMD_REJECT: begin
              if (out_free) begin
                pop        = 1'b1;
                emit       = 1'b1;
                res_status = STAT_REJECTED;
              end
            end
            default: begin
              pop = 1'b0;
            end
          endcase
        end
      end
      B_PICK: begin
        if (out_free) begin
          emit = 1'b1;
          if (kind == CMD_ALLOC) begin
            if (any) begin
              res_idx    = pick_idx;
              res_free   = free_dec;
              res_active = active_inc;
              wr_en      = 1'b1;
              wr_idx     = pick_idx;
              wr_val     = ST_QUERY_PENDING;
              ptr_en     = 1'b1;
            end else begin
              res_status = STAT_FULL;
            end
          end else begin
            if (any) begin
              res_idx  = pick_idx;
              res_last = (rest == '0);
            end else begin
              res_status = STAT_NO_MATCH;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      ptr          <= '0;
      free_slots   <= CNT_W'(SLOTS);
      active_slots <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= ST_READY_QUERY;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid    <= 1'b1;
        free_slots   <= res_free;
        active_slots <= res_active;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        slots[wr_idx] <= wr_val;
      end
      if (ptr_en) begin
        ptr <= (pick_idx == IDX_W'(SLOTS - 1)) ? '0 : pick_idx + 1'b1;
      end
    end
  end

  // Search registers and the output beat.
  always_ff @(posedge clk) begin
    if (capture) begin
      kind <= head.cmd.kind;
      vec  <= match;
      hi   <= match & ge_ptr;
    end else if (emit && state == B_PICK) begin
      vec <= rest;
    end
    if (emit) begin
      status       <= res_status;
      found_index  <= IDX_PORT_W'(res_idx);
      free_count   <= res_free;
      active_count <= res_active;
      last         <= res_last;
    end
  end

endmodule

// ===== rtl/core/query_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Query slot allocator
// Round-robin allocator over a table of query slot lifecycle states.
// ----------------------------------------------------------------------------
// A request beat is classified by the front end and queued; the back end owns
// the slot table, the search pointer and the free and active counters. A mark,
// a rollback or a rejected rollback is handled straight from the idle state
// and gives one result beat. An allocate first registers the ready flags of
// every slot together with the half at or above the search pointer, then picks
// the lowest flagged slot of that half (or of the whole table when the half is
// empty) and writes the result. A list request first registers the matching
// slots and then gives one result beat per matching slot, in ascending slot
// order, while the result register is free (a single status beat when nothing
// matches). The front end and a two-entry command queue keep accepting beats
// while the back end works or waits on a stalled result, and the result
// register lets the next command start as the current result is taken. Every
// slot state, the pointer and the counters are cleared directly by reset; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module query_slot_allocator_top #(
  parameter int SLOTS = qsa_pkg::DEFAULT_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     req_type,
  input  logic [qsa_pkg::IDX_PORT_W-1:0] slot_index,
  input  logic [1:0]                     target_state,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [qsa_pkg::IDX_PORT_W-1:0] found_index,
  output logic [qsa_pkg::CNT_W-1:0]      free_count,
  output logic [qsa_pkg::CNT_W-1:0]      active_count,
  output logic                           last
);
  import qsa_pkg::*;

  cmd_beat_t push;
  logic      push_ready;
  cmd_beat_t head;
  logic      pop;

  // Front end: takes the request beat and works out what the back end must do.
  qsa_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .slot_index   (slot_index),
    .target_state (target_state),
    .push         (push),
    .push_ready   (push_ready)
  );

  // Command queue so that either side may stall without holding up the other.
  qsa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // Back end: slot table, round-robin search, list walk and result register.
  qsa_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_index  (found_index),
    .free_count   (free_count),
    .active_count (active_count),
    .last         (last)
  );

endmodule

// ===== bench/query_slot_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query slot allocator testbench
// Drives allocate, mark, rollback and list request beats into the allocator.
// A local copy of the slot table predicts every result beat, and each result
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module query_slot_allocator_top_tb;
  import qsa_pkg::*;

  localparam int SLOTS        = DEFAULT_SLOTS;
  localparam int RANDOM_ITEMS = 450;
  // Accepted request beats after which the receiver holds off for a long stretch.
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  // Items left in the backlog when idling stops for the closing part of the run.
  localparam int TAIL_ITEMS   = 60;
  // Cycles without a single accepted beat before the run is abandoned.
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 100;
  localparam int MAX_PRINTED  = 30;

  // One request as it waits in the backlog. A request flagged to drain is
  // only offered once every predicted result beat has been delivered.
  typedef struct {
    req_t       req;
    logic [5:0] idx;
    slot_st_t   tgt;
    bit         drain;
  } slot_req_t;

  // One predicted result beat.
  typedef struct {
    status_t    st;
    logic [5:0] idx;
    logic [6:0] free_c;
    logic [6:0] active_c;
    logic       last;
  } slot_beat_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type     = '0;
  logic [IDX_PORT_W-1:0] slot_index   = '0;
  logic [1:0]            target_state = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [1:0]            status;
  logic [IDX_PORT_W-1:0] found_index;
  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      active_count;
  logic                  last;

  query_slot_allocator_top #(.SLOTS(SLOTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .slot_index   (slot_index),
    .target_state (target_state),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_index  (found_index),
    .free_count   (free_count),
    .active_count (active_count),
    .last         (last)
  );

  // --------------------------------------------------------------------------
  // Predicted copy of the block's state. It starts in the reset state, and
  // reset is applied only once, so no separate clear is needed.
  // --------------------------------------------------------------------------
  slot_st_t    slot_life [SLOTS];
  int unsigned search_ptr = 0;
  int unsigned free_cnt   = SLOTS;
  int unsigned active_cnt = 0;

  slot_req_t  req_backlog[$];
  slot_beat_t expected_beats[$];

  int  mismatches = 0;
  int  beats_in   = 0;   // accepted request beats, written with nonblocking
  bit  exp_empty  = 1'b1; // copy of "nothing outstanding" as seen after the last edge
  bit  quiet_tail = 1'b0; // set once the closing part of the run is reached

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_life[i] = ST_READY_QUERY;
  end

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic void push_beat(status_t st, int unsigned idx, bit is_last);
    slot_beat_t b;
    b.st       = st;
    b.idx      = idx[5:0];
    b.free_c   = free_cnt[6:0];
    b.active_c = active_cnt[6:0];
    b.last     = is_last;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // Works out the result beats of one accepted request and moves the
  // predicted slot table, pointer and counters on accordingly.
  function automatic void predict_slot_beats(slot_req_t r);
    int unsigned s;
    int          i;
    int          hit_count;
    bit          hit;
    hit       = 1'b0;
    hit_count = 0;
    case (r.req)
      REQ_ALLOC: begin
        // Round-robin search from the pointer, wrapping round the table.
        for (i = 0; i < SLOTS; i++) begin
          s = (search_ptr + i) % SLOTS;
          if (!hit && slot_life[s] == ST_READY_QUERY) begin
            hit          = 1'b1;
            slot_life[s] = ST_QUERY_PENDING;
            search_ptr   = (s + 1) % SLOTS;
            if (free_cnt > 0) free_cnt--;
            if (active_cnt < SLOTS) active_cnt++;
            push_beat(STAT_OK, s, 1'b1);
          end
        end
        if (!hit) push_beat(STAT_FULL, 0, 1'b1);
      end
      REQ_MARK, REQ_ROLLBACK: begin
        if (r.req == REQ_ROLLBACK && r.tgt != ST_READY_QUERY && r.tgt != ST_READY_RESET) begin
          push_beat(STAT_REJECTED, 0, 1'b1);
        end else begin
          if (r.idx < SLOTS) begin
            slot_life[r.idx] = r.tgt;
            // Counters move even when the slot was already ready for a query.
            if (r.tgt == ST_READY_QUERY) begin
              if (free_cnt < SLOTS) free_cnt++;
              if (active_cnt > 0) active_cnt--;
            end
          end
          push_beat(STAT_OK, 0, 1'b1);
        end
      end
      default: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_life[i] == r.tgt) begin
            push_beat(STAT_OK, i, 1'b0);
            hit_count++;
          end
        end
        if (hit_count == 0) push_beat(STAT_NO_MATCH, 0, 1'b1);
        else expected_beats[$].last = 1'b1;
      end
    endcase
  endfunction

  function automatic void queue_req(req_t r, int unsigned idx, slot_st_t t, bit drain = 1'b0);
    slot_req_t it;
    it.req   = r;
    it.idx   = idx[5:0];
    it.tgt   = t;
    it.drain = drain;
    req_backlog.insert(req_backlog.size(), it);
  endfunction

  // Random request mix. Most of it is shaped as lifecycle traffic: runs of
  // allocations that can drive the table full, releases that walk slots back
  // through reset to ready, and lists; the remainder is unconstrained noise.
  function automatic void fill_random_part();
    int n;
    int k;
    int unsigned pick;
    int unsigned s;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        k = $urandom_range(4, 40);
        repeat (k) queue_req(REQ_ALLOC, $urandom_range(0, 63), slot_st_t'($urandom_range(0, 3)));
        n += k;
      end else if (pick < 65) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          s = $urandom_range(0, SLOTS - 1);
          queue_req(REQ_MARK, s, ST_RESET_PENDING);
          queue_req(REQ_ROLLBACK, s, ST_READY_RESET);
          if ($urandom_range(0, 3) == 0) queue_req(REQ_ROLLBACK, s, ST_READY_QUERY);
          else queue_req(REQ_MARK, s, ST_READY_QUERY);
          n += 3;
        end
      end else if (pick < 85) begin
        queue_req(REQ_LIST, $urandom_range(0, 63), slot_st_t'($urandom_range(0, 3)));
        n++;
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) queue_req(req_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                             slot_st_t'($urandom_range(0, 3)));
        n += k;
      end
      // Partway through, the sender waits for the block to empty once more.
      if (n >= 300 && n < 300 + k + 3) req_backlog[$].drain = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver. A new beat is only put up once the previous one has been
  // taken, so valid and the payload hold steady until acceptance. Idle bursts
  // are inserted between beats, never in the middle of one.
  // --------------------------------------------------------------------------
  int tx_idle = 0;

  always @(posedge clk) begin
    slot_req_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_idle > 0) begin
        tx_idle--;
        in_valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (req_backlog[0].drain && (in_valid || !exp_empty)) begin
        // Hold back until every predicted beat has come out of the block.
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        tx_idle = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        it = req_backlog.pop_front();
        in_valid     <= 1'b1;
        req_type     <= it.req;
        slot_index   <= it.idx;
        target_state <= it.tgt;
      end
      quiet_tail <= (req_backlog.size() < TAIL_ITEMS);
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Besides the short idle bursts it holds off once for a
  // long stretch, so that the command queue fills and the input stalls.
  // --------------------------------------------------------------------------
  int rx_idle   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      rx_idle = $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Result beats are checked before the request accepted at the same
  // edge is predicted; a request's own results can never leave at its edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    slot_beat_t want;
    slot_req_t  seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          note_mismatch("result beat with nothing outstanding", found_index, 0);
        end else begin
          want = expected_beats.pop_front();
          if (status !== want.st) note_mismatch("status", status, want.st);
          if (found_index !== want.idx) note_mismatch("found_index", found_index, want.idx);
          if (free_count !== want.free_c) note_mismatch("free_count", free_count, want.free_c);
          if (active_count !== want.active_c)
            note_mismatch("active_count", active_count, want.active_c);
          if (last !== want.last) note_mismatch("last", last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        seen.req   = req_t'(req_type);
        seen.idx   = slot_index;
        seen.tgt   = slot_st_t'(target_state);
        seen.drain = 1'b0;
        predict_slot_beats(seen);
        beats_in <= beats_in + 1;
      end
      exp_empty <= (expected_beats.size() == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no beat accepted on either side means
  // the block has hung.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    // Directed opening: every request type, every target state, the index
    // extremes, rejected rollbacks, a list with no match, and both counters
    // pinned at their limits by marking already-ready slots ready again.
    queue_req(REQ_LIST, 0, ST_READY_QUERY);         // every slot matches
    queue_req(REQ_ALLOC, 0, ST_READY_QUERY);
    queue_req(REQ_ALLOC, 63, ST_RESET_PENDING);
    queue_req(REQ_MARK, 63, ST_RESET_PENDING);
    queue_req(REQ_MARK, 0, ST_READY_RESET);
    queue_req(REQ_ROLLBACK, 1, ST_QUERY_PENDING);   // rejected
    queue_req(REQ_ROLLBACK, 63, ST_RESET_PENDING);  // rejected
    queue_req(REQ_ROLLBACK, 1, ST_READY_RESET);
    queue_req(REQ_ROLLBACK, 0, ST_READY_QUERY);
    queue_req(REQ_MARK, 5, ST_READY_QUERY);         // counters reach their limits
    queue_req(REQ_MARK, 6, ST_READY_QUERY);         // and saturate there
    queue_req(REQ_LIST, 0, ST_QUERY_PENDING);       // nothing matches
    queue_req(REQ_LIST, 21, ST_READY_RESET);
    queue_req(REQ_LIST, 42, ST_RESET_PENDING);
    queue_req(REQ_MARK, 42, ST_QUERY_PENDING);
    queue_req(REQ_ALLOC, 21, ST_READY_RESET);
    queue_req(REQ_MARK, 62, ST_QUERY_PENDING);
    queue_req(REQ_MARK, 63, ST_READY_QUERY);
    queue_req(REQ_MARK, 0, ST_QUERY_PENDING);
    queue_req(REQ_LIST, 63, ST_QUERY_PENDING);
    queue_req(REQ_ALLOC, 0, ST_READY_QUERY, 1'b1);  // offered only once drained
    fill_random_part();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sampling on the falling edge keeps these checks clear of the clocked blocks.
    while (req_backlog.size() != 0 || in_valid || !exp_empty) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (expected_beats.size() != 0)
      note_mismatch("result beats never delivered", 0, expected_beats.size());
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
